// File: rtl/core/bbd_pkg.sv
// Shared types and constants of the BRIEF descriptor block.
// Used by the top level, the patch address unit and the port checker.
// Depends on nothing else.

package bbd_pkg;

    // Geometry and sizes
    localparam int PATCH_SIDE_DEFAULT = 48;
    localparam int TEST_COUNT         = 256;
    localparam int TEST_IDX_W         = 8;
    localparam int WORD_W             = 64;
    localparam int WORD_COUNT         = 4;
    localparam int DESC_W             = WORD_W * WORD_COUNT;
    localparam int OFFSET_W           = 6;
    localparam int COORD_W            = 8;
    localparam int PIXEL_W            = 8;
    localparam int PAIR_W             = 4 * OFFSET_W;

    // Configuration registers
    localparam int CFG_W       = 13;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;

    // Item operations; the fourth code is unused and ignored
    typedef enum logic [1:0] {
        OP_LOAD_PAIR  = 2'd0,
        OP_LOAD_PIXEL = 2'd1,
        OP_DESCRIBE   = 2'd2
    } op_t;

    // Patch coordinate pair handed to the address unit; may lie outside the patch
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } coord_t;

endpackage

// File: rtl/core/bbd_addr_gen.sv
// Patch address unit: clamps a column and row to the patch and forms the linear address.
// Shared by pixel loads and by both points of every pair test.
// Depends on bbd_pkg.

module bbd_addr_gen #(
    parameter int PATCH_SIDE = bbd_pkg::PATCH_SIDE_DEFAULT,
    parameter int AW         = $clog2(PATCH_SIDE * PATCH_SIDE)
) (
    input  bbd_pkg::coord_t coord,
    output logic [AW-1:0]   addr
);

    localparam int CW = $clog2(PATCH_SIDE);

    // Two's complement coordinate clamped to 0 .. PATCH_SIDE-1
    function automatic logic [CW-1:0] clamp(input logic [bbd_pkg::COORD_W-1:0] c);
        logic [CW-1:0] r;
        if (c[bbd_pkg::COORD_W-1])
        begin
            r = '0;
        end
        else if (c > bbd_pkg::COORD_W'(PATCH_SIDE - 1))
        begin
            r = CW'(PATCH_SIDE - 1);
        end
        else
        begin
            r = c[CW-1:0];
        end
        return r;
    endfunction

    logic [CW-1:0] col_clamped;
    logic [CW-1:0] row_clamped;

    // Row-major address, the multiply is by a constant
    always_comb
    begin
        col_clamped = clamp(coord.col);
        row_clamped = clamp(coord.row);
        addr        = AW'(row_clamped) * AW'(PATCH_SIDE) + AW'(col_clamped);
    end

endmodule

// File: rtl/core/brief_binary_descriptor.sv
// Top level of the BRIEF descriptor block: ports, stores, sequencer and result register.
// Depends on bbd_pkg and bbd_addr_gen.
//
// Load-pair and load-pixel items leave the block in its idle state, so it is ready again at
// the next edge. A describe item whose keypoint lies within PATCH_SIDE/2 pixels of a
// border completes with an all-zero descriptor; otherwise it runs the 256 pair tests
// one after another, each in four steps (pair table read, pixel a read, pixel b read,
// compare). The single read port of the patch store and the shared address unit keep
// these steps apart. The block takes no item while a describe
// is running; a finished result waits in its own register, so loads and the next
// describe may proceed while it is still untaken. Neither store is cleared after reset:
// entries must be written before they are used.

module brief_binary_descriptor #(
    parameter int PATCH_SIDE = bbd_pkg::PATCH_SIDE_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    // Configuration writes
    input  logic                                   cfg_write,
    input  logic [bbd_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [bbd_pkg::CFG_W-1:0]              cfg_data,

    // Input items
    input  logic                                   item_valid,
    output logic                                   item_ready,
    input  logic [1:0]                             operation,
    input  logic [7:0]                             pair_index,
    input  logic signed [bbd_pkg::OFFSET_W-1:0]    point_a_dx,
    input  logic signed [bbd_pkg::OFFSET_W-1:0]    point_a_dy,
    input  logic signed [bbd_pkg::OFFSET_W-1:0]    point_b_dx,
    input  logic signed [bbd_pkg::OFFSET_W-1:0]    point_b_dy,
    input  logic [5:0]                             patch_col,
    input  logic [5:0]                             patch_row,
    input  logic [bbd_pkg::PIXEL_W-1:0]            pixel,
    input  logic [11:0]                            center_x,
    input  logic [11:0]                            center_y,

    // Results
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic                                   in_bounds,
    output logic [bbd_pkg::WORD_W-1:0]             descriptor_word0,
    output logic [bbd_pkg::WORD_W-1:0]             descriptor_word1,
    output logic [bbd_pkg::WORD_W-1:0]             descriptor_word2,
    output logic [bbd_pkg::WORD_W-1:0]             descriptor_word3
);

    localparam int HALF_SIDE   = PATCH_SIDE / 2;
    localparam int PATCH_CELLS = PATCH_SIDE * PATCH_SIDE;
    localparam int AW          = $clog2(PATCH_CELLS);
    localparam int BORDER_W    = 14;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAIR,
        S_ADDR_A,
        S_ADDR_B,
        S_CMP,
        S_DONE
    } state_t;

    // Registers
    state_t                              state_reg,        state_next;
    logic [bbd_pkg::TEST_IDX_W-1:0]      test_idx_reg,     test_idx_next;
    logic [bbd_pkg::PIXEL_W-1:0]         pix_a_reg,        pix_a_next;
    logic [bbd_pkg::DESC_W-1:0]          desc_reg,         desc_next;
    logic                                fits_reg,         fits_next;
    logic                                result_valid_reg, result_valid_next;
    logic                                in_bounds_reg,    in_bounds_next;
    logic [bbd_pkg::DESC_W-1:0]          result_desc_reg,  result_desc_next;
    logic [bbd_pkg::CFG_W-1:0]           width_reg;
    logic [bbd_pkg::CFG_W-1:0]           height_reg;

    // Store read data
    logic [bbd_pkg::PAIR_W-1:0]          pair_rd_reg;
    logic [bbd_pkg::PIXEL_W-1:0]         pix_rd_reg;

    // Stores
    logic [bbd_pkg::PAIR_W-1:0]          pair_mem  [bbd_pkg::TEST_COUNT];
    logic [bbd_pkg::PIXEL_W-1:0]         patch_mem [PATCH_CELLS];

    logic                                item_xfer;
    logic                                pair_we;
    logic                                pixel_we;
    logic                                describe_go;
    logic                                fits_now;
    bbd_pkg::coord_t                     coord;
    logic [AW-1:0]                       patch_addr;
    logic [bbd_pkg::OFFSET_W-1:0]        off_col;
    logic [bbd_pkg::OFFSET_W-1:0]        off_row;

    assign item_ready = (state_reg == S_IDLE);
    assign item_xfer  = item_valid && item_ready;
    assign pair_we    = item_xfer && (operation == bbd_pkg::OP_LOAD_PAIR);
    assign pixel_we   = item_xfer && (operation == bbd_pkg::OP_LOAD_PIXEL)
                        && ({1'b0, patch_col} < 7'(PATCH_SIDE))
                        && ({1'b0, patch_row} < 7'(PATCH_SIDE));
    assign describe_go = item_xfer && (operation == bbd_pkg::OP_DESCRIBE);

    // Border check: HALF_SIDE <= c and c + HALF_SIDE + 1 <= image size, on both axes
    always_comb
    begin
        fits_now = (BORDER_W'(center_x) >= BORDER_W'(HALF_SIDE))
                && (BORDER_W'(center_x) + BORDER_W'(HALF_SIDE + 1) <= BORDER_W'(width_reg))
                && (BORDER_W'(center_y) >= BORDER_W'(HALF_SIDE))
                && (BORDER_W'(center_y) + BORDER_W'(HALF_SIDE + 1) <= BORDER_W'(height_reg));
    end

    // Address unit input: the load position, or point a or b of the current pair
    always_comb
    begin
        off_col = pair_rd_reg[4*bbd_pkg::OFFSET_W-1:3*bbd_pkg::OFFSET_W];
        off_row = pair_rd_reg[3*bbd_pkg::OFFSET_W-1:2*bbd_pkg::OFFSET_W];
        if (state_reg == S_ADDR_B)
        begin
            off_col = pair_rd_reg[2*bbd_pkg::OFFSET_W-1:bbd_pkg::OFFSET_W];
            off_row = pair_rd_reg[bbd_pkg::OFFSET_W-1:0];
        end
        if ((state_reg == S_ADDR_A) || (state_reg == S_ADDR_B))
        begin
            coord.col = {{(bbd_pkg::COORD_W - bbd_pkg::OFFSET_W){off_col[bbd_pkg::OFFSET_W-1]}},
                         off_col} + bbd_pkg::COORD_W'(HALF_SIDE);
            coord.row = {{(bbd_pkg::COORD_W - bbd_pkg::OFFSET_W){off_row[bbd_pkg::OFFSET_W-1]}},
                         off_row} + bbd_pkg::COORD_W'(HALF_SIDE);
        end
        else
        begin
            coord.col = bbd_pkg::COORD_W'(patch_col);
            coord.row = bbd_pkg::COORD_W'(patch_row);
        end
    end

    bbd_addr_gen #(
        .PATCH_SIDE (PATCH_SIDE),
        .AW         (AW)
    ) u_addr_gen (
        .coord (coord),
        .addr  (patch_addr)
    );

    // Test pair table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (pair_we)
        begin
            pair_mem[pair_index] <= {point_a_dx, point_a_dy, point_b_dx, point_b_dy};
        end
        pair_rd_reg <= pair_mem[test_idx_reg];
    end

    // Patch store: single port, written by pixel loads and read during a describe
    always_ff @(posedge clk)
    begin
        if (pixel_we)
        begin
            patch_mem[patch_addr] <= pixel;
        end
        pix_rd_reg <= patch_mem[patch_addr];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bbd_pkg::IMAGE_WIDTH_RESET;
            height_reg <= bbd_pkg::IMAGE_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bbd_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                bbd_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Sequencer next-state logic
    always_comb
    begin
        state_next        = state_reg;
        test_idx_next     = test_idx_reg;
        pix_a_next        = pix_a_reg;
        desc_next         = desc_reg;
        fits_next         = fits_reg;
        result_valid_next = result_valid_reg;
        in_bounds_next    = in_bounds_reg;
        result_desc_next  = result_desc_reg;

        // The result register empties when the downstream side takes it
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (describe_go)
                begin
                    test_idx_next = '0;
                    desc_next     = '0;
                    fits_next     = fits_now;
                    state_next    = fits_now ? S_PAIR : S_DONE;
                end
            end
            S_PAIR:
            begin
                state_next = S_ADDR_A;
            end
            S_ADDR_A:
            begin
                state_next = S_ADDR_B;
            end
            S_ADDR_B:
            begin
                pix_a_next = pix_rd_reg;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // Test results shift in from the top, so test 0 ends in bit 0
                desc_next     = {(pix_a_reg < pix_rd_reg), desc_reg[bbd_pkg::DESC_W-1:1]};
                test_idx_next = test_idx_reg + 1'b1;
                if (test_idx_reg == bbd_pkg::TEST_IDX_W'(bbd_pkg::TEST_COUNT - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PAIR;
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    in_bounds_next    = fits_reg;
                    result_desc_next  = desc_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            test_idx_reg     <= '0;
            pix_a_reg        <= '0;
            desc_reg         <= '0;
            fits_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            in_bounds_reg    <= 1'b0;
            result_desc_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            test_idx_reg     <= test_idx_next;
            pix_a_reg        <= pix_a_next;
            desc_reg         <= desc_next;
            fits_reg         <= fits_next;
            result_valid_reg <= result_valid_next;
            in_bounds_reg    <= in_bounds_next;
            result_desc_reg  <= result_desc_next;
        end
    end

    // Result ports
    assign result_valid     = result_valid_reg;
    assign in_bounds        = in_bounds_reg;
    assign descriptor_word0 = result_desc_reg[bbd_pkg::WORD_W-1:0];
    assign descriptor_word1 = result_desc_reg[2*bbd_pkg::WORD_W-1:bbd_pkg::WORD_W];
    assign descriptor_word2 = result_desc_reg[3*bbd_pkg::WORD_W-1:2*bbd_pkg::WORD_W];
    assign descriptor_word3 = result_desc_reg[4*bbd_pkg::WORD_W-1:3*bbd_pkg::WORD_W];

endmodule

// File: rtl/core/bbd_checker.sv
// Port-level checker for the BRIEF descriptor block, attached by the bind at the end.
// Depends on bbd_pkg; sees only the ports of brief_binary_descriptor.

module bbd_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    input  logic                                   item_ready,
    input  logic [1:0]                             operation,
    input  logic                                   result_valid,
    input  logic                                   result_ready,
    input  logic                                   in_bounds,
    input  logic [bbd_pkg::WORD_W-1:0]             descriptor_word0,
    input  logic [bbd_pkg::WORD_W-1:0]             descriptor_word1,
    input  logic [bbd_pkg::WORD_W-1:0]             descriptor_word2,
    input  logic [bbd_pkg::WORD_W-1:0]             descriptor_word3
);

    // A result that is held back stays put until it is transferred
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(in_bounds)
            && $stable(descriptor_word0) && $stable(descriptor_word1)
            && $stable(descriptor_word2) && $stable(descriptor_word3))
    else $error("held result changed before its transfer");

    // A keypoint too close to a border gives an all-zero descriptor
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !in_bounds |-> descriptor_word0 == '0 && descriptor_word1 == '0
            && descriptor_word2 == '0 && descriptor_word3 == '0)
    else $error("out-of-bounds result carries descriptor bits");

    // A describe transfer makes the block busy at the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && operation == bbd_pkg::OP_DESCRIBE |=> !item_ready)
    else $error("block still ready after a describe transfer");

    // A load transfer leaves the block ready at the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (operation == bbd_pkg::OP_LOAD_PAIR
            || operation == bbd_pkg::OP_LOAD_PIXEL) |=> item_ready)
    else $error("block not ready after a load transfer");

endmodule

bind brief_binary_descriptor bbd_checker u_bbd_checker (.*);

// File: dv/tb_brief_binary_descriptor.sv
// Self-checking testbench for the BRIEF descriptor block: loads test pairs and patch
// pixels, issues describe transfers under several image sizes and checks each result.
// Depends on bbd_pkg and the brief_binary_descriptor top level only.
`timescale 1ns / 100ps

module tb_brief_binary_descriptor;
    import bbd_pkg::*;

    localparam int PATCH_SIDE    = PATCH_SIDE_DEFAULT;
    localparam int HALF_SIDE     = PATCH_SIDE / 2;
    localparam int PATCH_CELLS   = PATCH_SIDE * PATCH_SIDE;
    localparam int OFFSET_LIMIT  = 2 ** (OFFSET_W - 1);
    localparam int CENTER_MAX    = 4095;
    localparam int IMAGE_MAX     = 4096;
    localparam int IDLE_PERCENT  = 10;
    localparam int SETTLE_CYCLES = 1100;
    localparam int HOLD_AFTER    = 8;
    localparam int HOLD_CYCLES   = 3000;
    localparam int STALL_LIMIT   = 20000;
    localparam int REPORT_LIMIT  = 10;

    // The fourth operation code is not decoded by the block
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One input transfer, every field at its port width
    typedef struct {
        logic [1:0]                 operation;
        logic [7:0]                 pair_index;
        logic signed [OFFSET_W-1:0] point_a_dx;
        logic signed [OFFSET_W-1:0] point_a_dy;
        logic signed [OFFSET_W-1:0] point_b_dx;
        logic signed [OFFSET_W-1:0] point_b_dy;
        logic [5:0]                 patch_col;
        logic [5:0]                 patch_row;
        logic [PIXEL_W-1:0]         pixel;
        logic [11:0]                center_x;
        logic [11:0]                center_y;
    } item_t;

    // One result transfer
    typedef struct packed {
        logic                               in_bounds;
        logic [WORD_COUNT-1:0][WORD_W-1:0]  words;
    } descriptor_t;

    typedef struct {
        int a_dx;
        int a_dy;
        int b_dx;
        int b_dy;
    } test_pair_t;

    // Predicts descriptors from its own copy of the pair table, patch and image size,
    // and compares each result transfer with the oldest prediction.
    class descriptor_scoreboard;
        test_pair_t         pair_table [TEST_COUNT];
        logic [PIXEL_W-1:0] patch_pixels [PATCH_CELLS];
        int                 image_width;
        int                 image_height;
        descriptor_t        expected_descriptors [$];
        int                 mismatches;

        function new();
            image_width  = IMAGE_WIDTH_RESET;
            image_height = IMAGE_HEIGHT_RESET;
            mismatches   = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_W-1:0] value);
            if (index == CFG_IMAGE_WIDTH)
                image_width = value;
            else if (index == CFG_IMAGE_HEIGHT)
                image_height = value;
        endfunction

        // Offsets that fall outside the patch are saturated to its nearest edge.
        function int patch_position(int offset);
            int c;
            c = offset + HALF_SIDE;
            if (c < 0)
                c = 0;
            if (c > PATCH_SIDE - 1)
                c = PATCH_SIDE - 1;
            return c;
        endfunction

        function logic [PIXEL_W-1:0] shade_at(int dx, int dy);
            return patch_pixels[patch_position(dy) * PATCH_SIDE + patch_position(dx)];
        endfunction

        function void note_item(item_t req);
            descriptor_t d;
            int          cx;
            int          cy;
            int          i;

            case (req.operation)
                OP_LOAD_PAIR:
                begin
                    pair_table[req.pair_index] = '{req.point_a_dx, req.point_a_dy,
                                                   req.point_b_dx, req.point_b_dy};
                end
                OP_LOAD_PIXEL:
                begin
                    if (req.patch_col < PATCH_SIDE && req.patch_row < PATCH_SIDE)
                        patch_pixels[req.patch_row * PATCH_SIDE + req.patch_col] = req.pixel;
                end
                OP_DESCRIBE:
                begin
                    cx = req.center_x;
                    cy = req.center_y;
                    d  = '0;
                    d.in_bounds = cx >= HALF_SIDE && cx <= image_width - HALF_SIDE - 1 &&
                                  cy >= HALF_SIDE && cy <= image_height - HALF_SIDE - 1;
                    if (d.in_bounds)
                    begin
                        for (i = 0; i < TEST_COUNT; i++)
                        begin
                            if (shade_at(pair_table[i].a_dx, pair_table[i].a_dy) <
                                shade_at(pair_table[i].b_dx, pair_table[i].b_dy))
                                d.words[i / WORD_W][i % WORD_W] = 1'b1;
                        end
                    end
                    expected_descriptors = {expected_descriptors, d};
                end
                default:
                begin
                end
            endcase
        endfunction

        function void note_mismatch(string field, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("descriptor mismatch on %s: expected %h, got %h", field, want, got);
        endfunction

        function void check_descriptor(descriptor_t got);
            descriptor_t want;
            int          w;

            if (expected_descriptors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("descriptor transfer with none outstanding: in_bounds %b, %h",
                             got.in_bounds, got.words);
                return;
            end
            want = expected_descriptors.pop_front();
            if (got.in_bounds !== want.in_bounds)
                note_mismatch("in_bounds", want.in_bounds, got.in_bounds);
            for (w = 0; w < WORD_COUNT; w++)
            begin
                if (got.words[w] !== want.words[w])
                    note_mismatch($sformatf("descriptor_word%0d", w), want.words[w], got.words[w]);
            end
        endfunction

        function int pending();
            return expected_descriptors.size();
        endfunction

        function bit failed();
            return mismatches != 0 || expected_descriptors.size() != 0;
        endfunction
    endclass

    // Block ports
    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;
    logic                       item_valid = 1'b0;
    logic                       item_ready;
    logic [1:0]                 operation = '0;
    logic [7:0]                 pair_index = '0;
    logic signed [OFFSET_W-1:0] point_a_dx = '0;
    logic signed [OFFSET_W-1:0] point_a_dy = '0;
    logic signed [OFFSET_W-1:0] point_b_dx = '0;
    logic signed [OFFSET_W-1:0] point_b_dy = '0;
    logic [5:0]                 patch_col = '0;
    logic [5:0]                 patch_row = '0;
    logic [PIXEL_W-1:0]         pixel = '0;
    logic [11:0]                center_x = '0;
    logic [11:0]                center_y = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic                       in_bounds;
    logic [WORD_W-1:0]          descriptor_word0;
    logic [WORD_W-1:0]          descriptor_word1;
    logic [WORD_W-1:0]          descriptor_word2;
    logic [WORD_W-1:0]          descriptor_word3;

    descriptor_scoreboard store;

    // Stimulus bookkeeping: which patch pixels and pairs hold written values
    bit spot_written [PATCH_CELLS];
    int written_spots [$];
    bit pair_written [TEST_COUNT];
    int image_w = IMAGE_WIDTH_RESET;
    int image_h = IMAGE_HEIGHT_RESET;
    bit quiet = 1'b0;
    int results_taken = 0;

    brief_binary_descriptor dut (.*);

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random content in every field; each sender overrides what its operation uses.
    function automatic item_t noise_item();
        item_t req;
        req.operation  = 2'($urandom_range(3));
        req.pair_index = 8'($urandom_range(255));
        req.point_a_dx = 6'($urandom_range(63));
        req.point_a_dy = 6'($urandom_range(63));
        req.point_b_dx = 6'($urandom_range(63));
        req.point_b_dy = 6'($urandom_range(63));
        req.patch_col  = 6'($urandom_range(63));
        req.patch_row  = 6'($urandom_range(63));
        req.pixel      = 8'($urandom_range(255));
        req.center_x   = 12'($urandom_range(CENTER_MAX));
        req.center_y   = 12'($urandom_range(CENTER_MAX));
        return req;
    endfunction

    // Offset that lands on a given patch coordinate; edge coordinates sometimes
    // use an offset beyond the patch that saturates onto them.
    function automatic int offset_for(int coord);
        int off;
        off = coord - HALF_SIDE;
        if (coord == 0 && $urandom_range(1) == 0)
            off = -int'($urandom_range(OFFSET_LIMIT, HALF_SIDE + 1));
        else if (coord == PATCH_SIDE - 1 && $urandom_range(1) == 0)
            off = $urandom_range(OFFSET_LIMIT - 1, HALF_SIDE);
        return off;
    endfunction

    // Centre coordinate on either side of one border of the image
    function automatic int border_coord(int limit);
        int c;
        case ($urandom_range(3))
            0: c = HALF_SIDE - 1;
            1: c = HALF_SIDE;
            2: c = limit - HALF_SIDE - 1;
            default: c = limit - HALF_SIDE;
        endcase
        if (c < 0)
            c = 0;
        if (c > CENTER_MAX)
            c = CENTER_MAX;
        return c;
    endfunction

    // Offer one transfer, holding it until accepted, with an occasional gap ahead of it.
    task automatic send_item(input item_t req);
        int spot;

        if (!quiet && $urandom_range(99) < IDLE_PERCENT)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        operation  <= req.operation;
        pair_index <= req.pair_index;
        point_a_dx <= req.point_a_dx;
        point_a_dy <= req.point_a_dy;
        point_b_dx <= req.point_b_dx;
        point_b_dy <= req.point_b_dy;
        patch_col  <= req.patch_col;
        patch_row  <= req.patch_row;
        pixel      <= req.pixel;
        center_x   <= req.center_x;
        center_y   <= req.center_y;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        store.note_item(req);

        if (req.operation == OP_LOAD_PAIR)
            pair_written[req.pair_index] = 1'b1;
        if (req.operation == OP_LOAD_PIXEL && req.patch_col < PATCH_SIDE &&
            req.patch_row < PATCH_SIDE)
        begin
            spot = req.patch_row * PATCH_SIDE + req.patch_col;
            if (!spot_written[spot])
            begin
                spot_written[spot] = 1'b1;
                written_spots = {written_spots, spot};
            end
        end
    endtask

    task automatic send_pixel(input int col, input int row, input int value);
        item_t req;
        req = noise_item();
        req.operation = OP_LOAD_PIXEL;
        req.patch_col = 6'(col);
        req.patch_row = 6'(row);
        req.pixel     = 8'(value);
        send_item(req);
    endtask

    task automatic send_pair_offsets(input int index, input int adx, input int ady,
                                     input int bdx, input int bdy);
        item_t req;
        req = noise_item();
        req.operation  = OP_LOAD_PAIR;
        req.pair_index = 8'(index);
        req.point_a_dx = 6'(adx);
        req.point_a_dy = 6'(ady);
        req.point_b_dx = 6'(bdx);
        req.point_b_dy = 6'(bdy);
        send_item(req);
    endtask

    // A pair whose two points only ever land on pixels already loaded
    task automatic send_pair(input int index);
        int spot_a;
        int spot_b;
        spot_a = written_spots[$urandom_range(written_spots.size() - 1)];
        spot_b = written_spots[$urandom_range(written_spots.size() - 1)];
        send_pair_offsets(index, offset_for(spot_a % PATCH_SIDE), offset_for(spot_a / PATCH_SIDE),
                          offset_for(spot_b % PATCH_SIDE), offset_for(spot_b / PATCH_SIDE));
    endtask

    task automatic send_describe(input int cx, input int cy);
        item_t req;
        req = noise_item();
        req.operation = OP_DESCRIBE;
        req.center_x  = 12'(cx);
        req.center_y  = 12'(cy);
        send_item(req);
    endtask

    task automatic send_unused();
        item_t req;
        req = noise_item();
        req.operation = OP_UNUSED;
        send_item(req);
    endtask

    // Mostly keypoints inside the image, then the borders, then anywhere at all.
    task automatic send_random_describe();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55 && image_w > 2 * HALF_SIDE && image_h > 2 * HALF_SIDE)
            send_describe($urandom_range(image_w - HALF_SIDE - 1, HALF_SIDE),
                          $urandom_range(image_h - HALF_SIDE - 1, HALF_SIDE));
        else if (pick < 80)
            send_describe(border_coord(image_w), border_coord(image_h));
        else
            send_describe($urandom_range(CENTER_MAX), $urandom_range(CENTER_MAX));
    endtask

    task automatic run_random_phase(input int count);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_pixel($urandom_range(PATCH_SIDE - 1), $urandom_range(PATCH_SIDE - 1),
                           $urandom_range(255));
            else if (pick < 75)
                send_pair($urandom_range(TEST_COUNT - 1));
            else if (pick < 88)
                send_random_describe();
            else if (pick < 93)
                send_unused();
            else if ($urandom_range(1) == 0)
                send_pixel($urandom_range(63), $urandom_range(63, PATCH_SIDE), $urandom_range(255));
            else
                send_pixel($urandom_range(63, PATCH_SIDE), $urandom_range(63), $urandom_range(255));
        end
    endtask

    // Wait for every outstanding descriptor, then give the block time to fall idle.
    task automatic wait_until_idle();
        item_valid <= 1'b0;
        while (store.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both image size registers on consecutive edges; only called while idle.
    task automatic set_image_size(input int width, input int height);
        cfg_write <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= CFG_W'(width);
        @(posedge clk);
        store.write_register(CFG_IMAGE_WIDTH, CFG_W'(width));
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= CFG_W'(height);
        @(posedge clk);
        store.write_register(CFG_IMAGE_HEIGHT, CFG_W'(height));
        cfg_write <= 1'b0;
        image_w = width;
        image_h = height;
    endtask

    // Result side: check each transfer, stall at random, and hold off once for a long spell.
    initial
    begin : result_sink
        descriptor_t got;
        int          hold_cycles;
        bit          held;

        hold_cycles = 0;
        held        = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                got.in_bounds = in_bounds;
                got.words     = {descriptor_word3, descriptor_word2,
                                 descriptor_word1, descriptor_word0};
                store.check_descriptor(got);
                results_taken++;
                if (results_taken == HOLD_AFTER && !held)
                begin
                    held        = 1'b1;
                    hold_cycles = HOLD_CYCLES;
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= quiet || $urandom_range(99) >= IDLE_PERCENT;
        end
    end

    // Watchdog: ends the run once neither channel has moved a transfer for too long.
    initial
    begin : watchdog
        int still_cycles;

        still_cycles = 0;
        while (still_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                still_cycles = 0;
            else
                still_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Main sequence
    initial
    begin : stimulus
        int idx;

        store = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Keypoints at the image corner and far outside the reset image size, before anything is loaded.
        send_describe(0, 0);
        send_describe(CENTER_MAX, CENTER_MAX);
        send_unused();

        // Patch corners and centre with varied intensities, then loads beyond the patch.
        send_pixel(0, 0, 0);
        send_pixel(PATCH_SIDE - 1, 0, 255);
        send_pixel(0, PATCH_SIDE - 1, 170);
        send_pixel(PATCH_SIDE - 1, PATCH_SIDE - 1, 85);
        send_pixel(HALF_SIDE, HALF_SIDE, 255);
        send_pixel(PATCH_SIDE, 5, 17);
        send_pixel(5, PATCH_SIDE, 34);
        send_pixel(63, 63, 51);

        // Extreme offsets, saturated offsets and a pair comparing a pixel with itself.
        send_pair_offsets(0, -OFFSET_LIMIT, -OFFSET_LIMIT, OFFSET_LIMIT - 1, OFFSET_LIMIT - 1);
        send_pair_offsets(TEST_COUNT - 1, -HALF_SIDE, HALF_SIDE - 1, HALF_SIDE - 1, -HALF_SIDE);
        send_pair_offsets(1, 0, 0, 0, 0);
        send_pair_offsets(TEST_COUNT / 2, HALF_SIDE - 1, HALF_SIDE - 1, -OFFSET_LIMIT,
                          OFFSET_LIMIT - 1);

        // Fill the rest of the pair table, loading patch pixels along the way.
        for (idx = 0; idx < TEST_COUNT; idx++)
        begin
            if (!pair_written[idx])
            begin
                if ($urandom_range(99) < 60)
                    send_pixel($urandom_range(PATCH_SIDE - 1), $urandom_range(PATCH_SIDE - 1),
                               $urandom_range(255));
                send_pair(idx);
            end
        end

        // Keypoints exactly on and just past each border of the reset image size.
        send_describe(HALF_SIDE, HALF_SIDE);
        send_describe(HALF_SIDE - 1, 300);
        send_describe(image_w - HALF_SIDE - 1, image_h - HALF_SIDE - 1);
        send_describe(image_w - HALF_SIDE, image_h - HALF_SIDE - 1);
        send_describe(300, image_h - HALF_SIDE);
        send_describe(300, HALF_SIDE - 1);

        run_random_phase(120);

        // Largest image, with neither side idling.
        wait_until_idle();
        set_image_size(IMAGE_MAX, IMAGE_MAX);
        quiet = 1'b1;
        run_random_phase(120);
        quiet = 1'b0;

        // Smallest image: every keypoint lies out of bounds.
        wait_until_idle();
        set_image_size(1, 1);
        run_random_phase(60);

        // Narrow image that admits a single keypoint column.
        wait_until_idle();
        set_image_size(2 * HALF_SIDE + 1, IMAGE_MAX);
        run_random_phase(100);

        // Arbitrary image size.
        wait_until_idle();
        set_image_size($urandom_range(IMAGE_MAX, 1), $urandom_range(IMAGE_MAX, 1));
        run_random_phase(120);

        wait_until_idle();
        if (!store.failed())
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
